>>> rtl/vps_pkg.sv
package vps_pkg;

    localparam int MAX_SPRITES_DEF = 64;
    localparam int PRIO_W          = 16;
    localparam int INDEX_W         = 6;

    // One slot of the insertion chain.
    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic [INDEX_W-1:0]       idx;
    } entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;   // place the incoming entry, push lower entries down
        logic drain;    // move every entry one slot toward the head
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMPTY
    } state_t;

endpackage

>>> rtl/visible_priority_stable_sorter.sv
// Load: one sprite record per cycle; each visible record is placed in the sorted chain at once.
// Output: after the last record, one result per cycle (under m_tready) from the chain head;
// a list of N stored visible sprites gives N results, an empty list one; input stalls meanwhile.
// The first result is valid the cycle after the last record is accepted.
// Reset (aresetn low, synchronous): all chain slots invalid, counters and flags cleared.
module visible_priority_stable_sorter
    import vps_pkg::*;
#(
    parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [15:0] priority_req (signed)
    input  logic       s_tuser,    // [0] visible
    input  logic       s_tlast,    // last record of the list

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [5:0] sprite_index, [7:6] zero
    output logic [1:0] m_tuser,    // [0] empty_res, [1] overflow
    output logic       m_tlast     // final_res
);

    localparam int CNT_W = $clog2(MAX_SPRITES + 1);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] arr_cnt_reg;
    logic [CNT_W-1:0] arr_cnt_next;
    logic             drop_reg;
    logic             drop_next;

    logic             s_hs;
    logic             m_hs;
    logic             room;
    logic             has_entry;

    cell_ctl_t        ctl;
    entry_t           new_ent;
    entry_t           chain [MAX_SPRITES];
    logic             keep  [MAX_SPRITES];
    entry_t           nil_ent;

    assign s_hs = s_tvalid && s_tready;
    assign m_hs = m_tvalid && m_tready;

    // A record finds room only while the list is below capacity.
    assign room = (arr_cnt_reg < CNT_W'(MAX_SPRITES));

    assign nil_ent = '{valid: 1'b0, prio: '0, idx: '0};

    assign new_ent.valid = 1'b1;
    assign new_ent.prio  = s_tdata;
    assign new_ent.idx   = INDEX_W'(arr_cnt_reg);

    // Insert visible records; drain moves the chain up one slot per accepted result.
    assign ctl.insert = s_hs && room && s_tuser;
    assign ctl.drain  = (state_reg == ST_DRAIN) && m_hs;

    // Anything stored once this record lands?
    assign has_entry = chain[0].valid || (room && s_tuser);

    for (genvar k = 0; k < MAX_SPRITES; k++) begin : g_cell
        entry_t up_e;
        entry_t down_e;
        logic   keep_u;

        if (k == 0) begin : g_head
            assign up_e   = nil_ent;
            assign keep_u = 1'b1;
        end else begin : g_mid
            assign up_e   = chain[k-1];
            assign keep_u = keep[k-1];
        end

        if (k == MAX_SPRITES - 1) begin : g_tail
            assign down_e = nil_ent;
        end else begin : g_body
            assign down_e = chain[k+1];
        end

        vps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .new_ent  (new_ent),
            .keep_up  (keep_u),
            .up_ent   (up_e),
            .down_ent (down_e),
            .ent      (chain[k]),
            .keep     (keep[k])
        );
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_hs && s_tlast) begin
                    state_next = has_entry ? ST_DRAIN : ST_EMPTY;
                end
            end
            ST_DRAIN: begin
                if (m_hs && !chain[1].valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_EMPTY: begin
                if (m_hs) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Counters and overflow flag: count arrivals, latch drops, clear at end of list.
    always_comb begin
        arr_cnt_next = arr_cnt_reg;
        drop_next    = drop_reg;
        if (s_hs) begin
            if (room) begin
                arr_cnt_next = arr_cnt_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
            if (s_tlast) begin
                arr_cnt_next = '0;
            end
        end
        if (m_hs && m_tlast) begin
            drop_next = 1'b0;
        end
    end

    // Output logic: results come straight from the chain head register.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tdata  = '0;
        m_tuser  = {drop_reg, 1'b0};
        m_tlast  = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
            end
            ST_DRAIN: begin
                m_tvalid = 1'b1;
                m_tdata  = {2'b00, chain[0].idx};
                m_tlast  = !chain[1].valid;
            end
            ST_EMPTY: begin
                m_tvalid = 1'b1;
                m_tuser  = {drop_reg, 1'b1};
                m_tlast  = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            arr_cnt_reg <= '0;
            drop_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            arr_cnt_reg <= arr_cnt_next;
            drop_reg    <= drop_next;
        end
    end

`ifndef SYNTHESIS
    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    // While draining the head slot always holds an entry.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> chain[0].valid)
        else $error("drain with empty chain head");

    // Arrival count stays within capacity.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        arr_cnt_reg <= CNT_W'(MAX_SPRITES))
        else $error("arrival count beyond capacity");

    // After the final result the chain is empty and loading resumes.
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_hs && m_tlast) |=> (state_reg == ST_LOAD) && !chain[0].valid && !drop_reg)
        else $error("chain not cleared after final result");
`endif

endmodule

>>> rtl/vps_cell.sv
module vps_cell
    import vps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  entry_t    new_ent,
    input  logic      keep_up,
    input  entry_t    up_ent,
    input  entry_t    down_ent,
    output entry_t    ent,
    output logic      keep
);

    entry_t ent_reg;
    entry_t ent_next;

    // Stay put when holding an equal or higher priority (stable order).
    assign keep = ent_reg.valid && (ent_reg.prio >= new_ent.prio);
    assign ent  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.drain) begin
            ent_next = down_ent;
        end else if (ctl.insert && !keep) begin
            ent_next = keep_up ? new_ent : up_ent;
        end
    end

    // Only the valid bit is reset; payload follows it freely.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg.valid <= ent_next.valid;
        end
        ent_reg.prio <= ent_next.prio;
        ent_reg.idx  <= ent_next.idx;
    end

endmodule
